// ===== design/mbf_pkg.sv =====
// Shared types and constants for the Morse bond force pipeline.
// No dependencies; imported by morse_bond_force_top.
package mbf_pkg;

	typedef enum logic [1:0] {
		REG_REST_LENGTH    = 2'd0,
		REG_WELL_WIDTH     = 2'd1,
		REG_WELL_DEPTH     = 2'd2,
		REG_BREAK_DISTANCE = 2'd3
	} cfg_reg_t;

	localparam logic [31:0] REST_LENGTH_RST    = 32'd65536;
	localparam logic [31:0] WELL_WIDTH_RST     = 32'd65536;
	localparam logic [31:0] WELL_DEPTH_RST     = 32'd65536;
	localparam logic [31:0] BREAK_DISTANCE_RST = 32'd196608;

	// log2(e) in Q2.30 and ln(2) in Q0.32.
	localparam logic signed [31:0] L2E_Q30 = 32'sd1549082005;
	localparam logic [31:0]        LN2_Q32 = 32'd2977044472;

	// Exponent argument limits in Q16.16: -24.0 and +11.0.
	localparam logic [21:0] Z_NEG_MAG = 22'd1572864;
	localparam logic [21:0] Z_POS_MAX = 22'd720896;

	localparam int EXP_TERMS = 12;
	localparam int SQ_STEPS  = 49;
	localparam int DIV_STEPS = 31;

	// Sideband that travels with each item down the pipeline.
	typedef struct packed {
		logic             brk;
		logic             zero;
		logic [2:0]       dneg;
		logic [2:0][32:0] mag;
	} side_t;

endpackage

// ===== design/morse_bond_force_top.sv =====
// Morse bond pair force: fully pipelined datapath with its config registers.
// Depends on mbf_pkg.
// Throughput: one pair per clock; busy is never raised and results cannot be stalled.
// The depth is set by the 49-step square root, the 12-term exponential series
// (three stages per term) and the wide multiplies cut into partial products.
// Reset clears the valid bits and loads the register defaults; datapath registers are not reset.
module morse_bond_force_top
	import mbf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] first_x,
	input  logic signed [31:0] first_y,
	input  logic signed [31:0] first_z,
	input  logic signed [31:0] second_x,
	input  logic signed [31:0] second_y,
	input  logic signed [31:0] second_z,
	output logic               done,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic signed [31:0] force_z,
	output logic               should_break,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int HAT_AT  = SQ_STEPS + DIV_STEPS;
	localparam int FM_AT   = SQ_STEPS + 5 + 3 * EXP_TERMS + 7;
	localparam int HAT_DLY = FM_AT - HAT_AT;
	localparam int OUT_AT  = FM_AT + 3;

	// ---------------- configuration ----------------
	logic [31:0] rest_q, width_q, depth_q, brkd_q;
	logic [63:0] bd_sq_q, m_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q  <= REST_LENGTH_RST;
			width_q <= WELL_WIDTH_RST;
			depth_q <= WELL_DEPTH_RST;
			brkd_q  <= BREAK_DISTANCE_RST;
			bd_sq_q <= 64'(BREAK_DISTANCE_RST) * 64'(BREAK_DISTANCE_RST);
			m_q     <= 64'(WELL_DEPTH_RST) * 64'(WELL_WIDTH_RST);
		end else begin
			bd_sq_q <= 64'(brkd_q) * 64'(brkd_q);
			m_q     <= 64'(depth_q) * 64'(width_q);
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_REST_LENGTH:    rest_q  <= cfg_data;
					REG_WELL_WIDTH:     width_q <= cfg_data;
					REG_WELL_DEPTH:     depth_q <= cfg_data;
					REG_BREAK_DISTANCE: brkd_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// ---------------- valid bits ----------------
	logic vld_s1, vld_s2;
	logic vld_s [0:OUT_AT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int j = 0; j <= OUT_AT; j++) vld_s[j] <= 1'b0;
		end else begin
			vld_s1   <= start && !busy;
			vld_s2   <= vld_s1;
			vld_s[0] <= vld_s2;
			for (int j = 1; j <= OUT_AT; j++) vld_s[j] <= vld_s[j-1];
		end
	end

	assign done = vld_s[OUT_AT];

	// ---------------- displacement and squares ----------------
	logic signed [31:0] pa [3];
	logic signed [31:0] pb [3];
	logic        [2:0]  dneg_s1, dneg_s2;
	logic        [32:0] mag_s1 [3];
	logic        [32:0] mag_s2 [3];
	logic        [65:0] sq_s2 [3];

	assign pa[0] = first_x;
	assign pa[1] = first_y;
	assign pa[2] = first_z;
	assign pb[0] = second_x;
	assign pb[1] = second_y;
	assign pb[2] = second_z;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			logic signed [32:0] dl;
			dl = {pa[i][31], pa[i]} - {pb[i][31], pb[i]};
			dneg_s1[i] <= dl[32];
			mag_s1[i]  <= dl[32] ? 33'(-dl) : 33'(dl);
			sq_s2[i]   <= 66'(mag_s1[i]) * 66'(mag_s1[i]);
			mag_s2[i]  <= mag_s1[i];
		end
		dneg_s2 <= dneg_s1;
	end

	// ---------------- sum of squares, break test ----------------
	side_t       side_s [0:OUT_AT];
	logic [65:0] sq_rad_s  [0:SQ_STEPS];
	logic [51:0] sq_rem_s  [0:SQ_STEPS];
	logic [48:0] sq_root_s [0:SQ_STEPS];
	logic [65:0] ssum;

	assign ssum = sq_s2[0] + sq_s2[1] + sq_s2[2];

	always_ff @(posedge clk) begin
		side_s[0].brk  <= ssum > {2'b00, bd_sq_q};
		side_s[0].zero <= ssum == 66'd0;
		side_s[0].dneg <= dneg_s2;
		for (int i = 0; i < 3; i++) side_s[0].mag[i] <= mag_s2[i];
		sq_rad_s[0]  <= ssum;
		sq_rem_s[0]  <= '0;
		sq_root_s[0] <= '0;
		for (int j = 1; j <= OUT_AT; j++) side_s[j] <= side_s[j-1];
	end

	// ---------------- square root, two radicand bits per stage ----------------
	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		localparam int POS = 2 * (SQ_STEPS - 1 - j) - 32;
		logic [1:0]  pair;
		logic [53:0] rem_in;
		logic [50:0] trial;

		if (POS >= 0) begin : g_pair
			assign pair = sq_rad_s[j][POS+1:POS];
		end else begin : g_nopair
			assign pair = 2'b00;
		end

		assign rem_in = {sq_rem_s[j], pair};
		assign trial  = {sq_root_s[j], 2'b01};

		always_ff @(posedge clk) begin
			sq_rad_s[j+1] <= sq_rad_s[j];
			if (rem_in >= 54'(trial)) begin
				sq_rem_s[j+1]  <= 52'(rem_in - 54'(trial));
				sq_root_s[j+1] <= {sq_root_s[j][47:0], 1'b1};
			end else begin
				sq_rem_s[j+1]  <= rem_in[51:0];
				sq_root_s[j+1] <= {sq_root_s[j][47:0], 1'b0};
			end
		end
	end

	// ---------------- unit vector: restoring division per axis ----------------
	// The quotient never exceeds 2^30, so only its low 31 bits are developed and
	// every numerator bit shifted in below them is zero.
	logic [48:0] dv_d_s [0:DIV_STEPS];
	logic [48:0] dv_rem_s [3][0:DIV_STEPS];
	logic [30:0] dv_q_s   [3][0:DIV_STEPS];
	logic [30:0] hat_s    [3][0:HAT_DLY];

	assign dv_d_s[0] = sq_root_s[SQ_STEPS];

	for (genvar a = 0; a < 3; a++) begin : g_axis
		assign dv_rem_s[a][0] = {1'b0, side_s[SQ_STEPS].mag[a], 15'd0};
		assign dv_q_s[a][0]   = '0;

		for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
			logic [49:0] r2;
			assign r2 = {dv_rem_s[a][s], 1'b0};
			always_ff @(posedge clk) begin
				if (r2 >= {1'b0, dv_d_s[s]}) begin
					dv_rem_s[a][s+1] <= 49'(r2 - {1'b0, dv_d_s[s]});
					dv_q_s[a][s+1]   <= {dv_q_s[a][s][29:0], 1'b1};
				end else begin
					dv_rem_s[a][s+1] <= r2[48:0];
					dv_q_s[a][s+1]   <= {dv_q_s[a][s][29:0], 1'b0};
				end
			end
		end

		assign hat_s[a][0] = dv_q_s[a][DIV_STEPS];
		for (genvar h = 0; h < HAT_DLY; h++) begin : g_hat
			always_ff @(posedge clk) hat_s[a][h+1] <= hat_s[a][h];
		end
	end

	for (genvar s = 0; s < DIV_STEPS; s++) begin : g_divd
		always_ff @(posedge clk) dv_d_s[s+1] <= dv_d_s[s];
	end

	// ---------------- exponent argument ----------------
	logic               tneg_s53;
	logic        [32:0] ut_s53;
	logic               tneg_s54;
	logic        [48:0] ph_s54;
	logic        [47:0] pl_s54;
	logic signed [21:0] z_s55;
	logic signed [53:0] w_s56;
	logic signed [7:0]  k_s57;
	logic        [63:0] rp_s57;

	always_ff @(posedge clk) begin
		logic [33:0]        t;
		logic [49:0]        u;
		logic signed [53:0] zx, lx;
		t        = {1'b0, sq_root_s[SQ_STEPS][48:16]} - {2'b00, rest_q};
		tneg_s53 <= t[33];
		ut_s53   <= t[33] ? 33'(-t) : t[32:0];

		tneg_s54 <= tneg_s53;
		ph_s54   <= 49'(width_q) * 49'(ut_s53[32:16]);
		pl_s54   <= 48'(width_q) * 48'(ut_s53[15:0]);

		u = 50'(ph_s54) + 50'(pl_s54[47:16]);
		if (!tneg_s54) begin
			z_s55 <= (u > 50'(Z_NEG_MAG)) ? -$signed(Z_NEG_MAG) : -$signed(u[21:0]);
		end else begin
			z_s55 <= (u > 50'(Z_POS_MAX)) ? $signed(Z_POS_MAX) : $signed(u[21:0]);
		end

		zx = 54'(z_s55);
		lx = 54'(L2E_Q30);
		w_s56 <= zx * lx;

		k_s57  <= w_s56[53:46];
		rp_s57 <= 64'(w_s56[45:14]) * 64'(LN2_Q32);
	end

	// ---------------- 2^f by Taylor series, three stages per term ----------------
	logic        [32:0] tc_term_s [0:EXP_TERMS];
	logic        [33:0] tc_sum_s  [0:EXP_TERMS];
	logic        [31:0] tc_r_s    [0:EXP_TERMS];
	logic signed [7:0]  tc_k_s    [0:EXP_TERMS];

	assign tc_term_s[0] = 33'h1_0000_0000;
	assign tc_sum_s[0]  = 34'h1_0000_0000;
	assign tc_r_s[0]    = rp_s57[63:32];
	assign tc_k_s[0]    = k_s57;

	for (genvar n = 1; n <= EXP_TERMS; n++) begin : g_term
		localparam logic [34:0] RCP = 35'((64'd1 << 34) / n);
		logic        [32:0] ta_x, tb_x, tb_q;
		logic        [33:0] ta_sum, tb_sum;
		logic        [31:0] ta_r, tb_r;
		logic signed [7:0]  ta_k, tb_k;
		logic        [64:0] p_a;
		logic        [67:0] p_b;
		logic        [36:0] rem;

		assign p_a = 65'(tc_term_s[n-1]) * 65'(tc_r_s[n-1]);
		assign p_b = 68'(ta_x) * 68'(RCP);
		assign rem = 37'(tb_x) - 37'(tb_q) * 37'(n);

		always_ff @(posedge clk) begin
			ta_x   <= p_a[64:32];
			ta_sum <= tc_sum_s[n-1];
			ta_r   <= tc_r_s[n-1];
			ta_k   <= tc_k_s[n-1];

			tb_x   <= ta_x;
			tb_q   <= p_b[66:34];
			tb_sum <= ta_sum;
			tb_r   <= ta_r;
			tb_k   <= ta_k;

			// The reciprocal estimate is at most one short of the true quotient.
			if (rem >= 37'(n)) begin
				tc_term_s[n] <= tb_q + 33'd1;
				tc_sum_s[n]  <= tb_sum + 34'(tb_q) + 34'd1;
			end else begin
				tc_term_s[n] <= tb_q;
				tc_sum_s[n]  <= tb_sum + 34'(tb_q);
			end
			tc_r_s[n] <= tb_r;
			tc_k_s[n] <= tb_k;
		end
	end

	// ---------------- scale, square, difference ----------------
	logic [48:0]  e_s94, e_s95, e_s96;
	logic [47:0]  hh_s95;
	logic [48:0]  hl_s95;
	logic [49:0]  ll_s95;
	logic [63:0]  e2_s96;
	logic         gneg_s97, gneg_s98, gneg_s99, gneg_s100, gneg_s101, gneg_s102;
	logic [63:0]  g_s97;
	logic [63:0]  mll_s98, mlh_s98, mhl_s98, mhh_s98;
	logic [127:0] p_s99;
	logic [62:0]  fm_s100;

	always_ff @(posedge clk) begin
		logic [7:0]  kn;
		logic [97:0] esq;
		kn = -tc_k_s[EXP_TERMS];
		if (!tc_k_s[EXP_TERMS][7]) begin
			e_s94 <= 49'({15'd0, tc_sum_s[EXP_TERMS]} << tc_k_s[EXP_TERMS][3:0]);
		end else begin
			e_s94 <= 49'(tc_sum_s[EXP_TERMS] >> kn[5:0]);
		end

		e_s95  <= e_s94;
		hh_s95 <= 48'(e_s94[48:25]) * 48'(e_s94[48:25]);
		hl_s95 <= 49'(e_s94[48:25]) * 49'(e_s94[24:0]);
		ll_s95 <= 50'(e_s94[24:0]) * 50'(e_s94[24:0]);

		esq    = {hh_s95, 50'd0} + 98'({hl_s95, 26'd0}) + 98'(ll_s95);
		e2_s96 <= esq[95:32];
		e_s96  <= e_s95;

		gneg_s97 <= e2_s96 < 64'(e_s96);
		g_s97    <= (e2_s96 < 64'(e_s96)) ? 64'(e_s96) - e2_s96 : e2_s96 - 64'(e_s96);

		gneg_s98 <= gneg_s97;
		mll_s98  <= 64'(m_q[31:0]) * 64'(g_s97[31:0]);
		mlh_s98  <= 64'(m_q[31:0]) * 64'(g_s97[63:32]);
		mhl_s98  <= 64'(m_q[63:32]) * 64'(g_s97[31:0]);
		mhh_s98  <= 64'(m_q[63:32]) * 64'(g_s97[63:32]);

		gneg_s99 <= gneg_s98;
		p_s99    <= {mhh_s98, 64'd0} + {32'd0, mlh_s98, 32'd0}
			+ {32'd0, mhl_s98, 32'd0} + {64'd0, mll_s98};

		gneg_s100 <= gneg_s99;
		fm_s100   <= (|p_s99[127:109]) ? 63'h4000_0000_0000_0000 : 63'(p_s99[108:47]);
	end

	// ---------------- force per axis, saturation ----------------
	logic [61:0] pf_hi_s101 [3];
	logic [62:0] pf_lo_s101 [3];
	logic [63:0] v_s102 [3];
	logic [31:0] fout [3];

	always_ff @(posedge clk) begin
		logic [93:0] pw;
		gneg_s101 <= gneg_s100;
		gneg_s102 <= gneg_s101;
		for (int a = 0; a < 3; a++) begin
			pf_hi_s101[a] <= 62'(fm_s100[62:32]) * 62'(hat_s[a][HAT_DLY]);
			pf_lo_s101[a] <= 63'(fm_s100[31:0]) * 63'(hat_s[a][HAT_DLY]);
			pw            = {pf_hi_s101[a], 32'd0} + 94'(pf_lo_s101[a]);
			v_s102[a]     <= 64'(pw[93:30]);
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (side_s[OUT_AT-1].zero || v_s102[a] == 64'd0) begin
				fout[a] = 32'd0;
			end else if (gneg_s102 != side_s[OUT_AT-1].dneg[a]) begin
				fout[a] = (v_s102[a] >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-v_s102[a]);
			end else begin
				fout[a] = (v_s102[a] >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v_s102[a][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		force_x      <= $signed(fout[0]);
		force_y      <= $signed(fout[1]);
		force_z      <= $signed(fout[2]);
		should_break <= side_s[OUT_AT-1].brk;
	end

	// ---------------- checks ----------------
	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[SQ_STEPS] |-> 52'(sq_rem_s[SQ_STEPS]) <= 52'({sq_root_s[SQ_STEPS], 1'b0}))
		else $error("square root remainder exceeds twice the root");

	a_hat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[HAT_AT] && !side_s[HAT_AT].zero |-> hat_s[0][0] <= 31'h4000_0000
			&& hat_s[1][0] <= 31'h4000_0000 && hat_s[2][0] <= 31'h4000_0000)
		else $error("unit vector component above one");

	a_fm_cap: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[FM_AT] |-> fm_s100 <= 63'h4000_0000_0000_0000)
		else $error("force magnitude above its cap");

	a_zero_force: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(side_s[OUT_AT-1].zero) |-> force_x == 32'sd0
			&& force_y == 32'sd0 && force_z == 32'sd0 && !should_break)
		else $error("coincident atoms gave a nonzero result");

endmodule
